@@ hw/rtl/ap_station_table_learner_unit_defines.svh @@
// ---------------------------------------------------------------------------
// Access point / station learner - assertion macros
// Shared concurrent assertion wrappers on aclk / aresetn.
// ---------------------------------------------------------------------------
`ifndef AP_STATION_TABLE_LEARNER_UNIT_DEFINES_SVH
`define AP_STATION_TABLE_LEARNER_UNIT_DEFINES_SVH

// checked only out of reset
`define APSTL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every edge, reset included
`define APSTL_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ hw/rtl/apstl_pkg.sv @@
// ---------------------------------------------------------------------------
// apstl_pkg
// Types and constants of the access point / station learning table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package apstl_pkg;

    localparam int AP_ENTRIES = 32;
    localparam int ST_ENTRIES = 16;

    localparam int AP_IDX_W  = (AP_ENTRIES > 1) ? $clog2(AP_ENTRIES) : 1;
    localparam int AP_CNT_W  = $clog2(AP_ENTRIES + 1);
    localparam int ST_IDX_W  = (ST_ENTRIES > 1) ? $clog2(ST_ENTRIES) : 1;
    localparam int ST_CNT_W  = $clog2(ST_ENTRIES + 1);
    localparam int ST_ADDR_W = AP_IDX_W + ST_IDX_W;

    localparam int ADDR_W     = 48;
    localparam int LEN_W      = 12;
    localparam int BYTE_W     = 8;
    localparam int KIND_W     = 2;
    localparam int ACTION_W   = 2;
    localparam int AP_SLOT_W  = 5;
    localparam int ST_SLOT_W  = 4;
    localparam int AP_TOTAL_W = 6;
    localparam int ST_TOTAL_W = 5;

    localparam logic [LEN_W-1:0] MIN_BEACON_RESET = 12'd70;

    localparam logic [KIND_W-1:0] KIND_OTHER  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BEACON = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    localparam logic [ACTION_W-1:0] ACT_NONE    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_CREATED = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_UPDATED = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_FULL    = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic [ADDR_W-1:0]        receiver_address;
        logic [ADDR_W-1:0]        transmitter_address;
        logic [ADDR_W-1:0]        bssid_address;
        logic [LEN_W-1:0]         frame_length;
        logic [BYTE_W-1:0]        ssid_length;
        logic [BYTE_W-1:0]        radio_channel;
        logic signed [BYTE_W-1:0] signal_strength;
    } in_t;

    typedef struct packed {
        logic [AP_SLOT_W-1:0]  ap_slot;
        logic [ACTION_W-1:0]   ap_action;
        logic [ST_SLOT_W-1:0]  station_slot;
        logic [ACTION_W-1:0]   station_action;
        logic [AP_TOTAL_W-1:0] ap_total;
        logic [ST_TOTAL_W-1:0] station_total;
    } out_t;

    typedef struct packed {
        logic [AP_IDX_W-1:0]  ap_addr;
        logic                 ap_bssid_we;
        logic                 ap_str_we;
        logic                 ap_chan_we;
        logic [ST_ADDR_W-1:0] st_addr;
        logic                 st_mac_we;
        logic                 st_str_we;
        logic [ADDR_W-1:0]    bssid;
        logic [ADDR_W-1:0]    mac;
        logic [BYTE_W-1:0]    strength;
        logic [BYTE_W-1:0]    channel;
    } store_ctl_t;

endpackage

@@ hw/rtl/apstl_store.sv @@
// ---------------------------------------------------------------------------
// apstl_store
// Access point and station tables, one port each, registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module apstl_store (
    input  logic                     aclk,
    input  apstl_pkg::store_ctl_t    ctl,
    output logic [apstl_pkg::ADDR_W-1:0] ap_bssid_q,
    output logic [apstl_pkg::ADDR_W-1:0] st_mac_q
);
    import apstl_pkg::*;

    localparam int ST_DEPTH = 1 << ST_ADDR_W;

    logic [ADDR_W-1:0] ap_bssid_mem [AP_ENTRIES];
    logic [BYTE_W-1:0] ap_str_mem   [AP_ENTRIES];
    logic [BYTE_W-1:0] ap_chan_mem  [AP_ENTRIES];
    logic [ADDR_W-1:0] st_mac_mem   [ST_DEPTH];
    logic [BYTE_W-1:0] st_str_mem   [ST_DEPTH];

    always_ff @(posedge aclk) begin
        if (ctl.ap_bssid_we) begin
            ap_bssid_mem[ctl.ap_addr] <= ctl.bssid;
        end
        if (ctl.ap_str_we) begin
            ap_str_mem[ctl.ap_addr] <= ctl.strength;
        end
        if (ctl.ap_chan_we) begin
            ap_chan_mem[ctl.ap_addr] <= ctl.channel;
        end
        ap_bssid_q <= ap_bssid_mem[ctl.ap_addr];
    end

    always_ff @(posedge aclk) begin
        if (ctl.st_mac_we) begin
            st_mac_mem[ctl.st_addr] <= ctl.mac;
        end
        if (ctl.st_str_we) begin
            st_str_mem[ctl.st_addr] <= ctl.strength;
        end
        st_mac_q <= st_mac_mem[ctl.st_addr];
    end

endmodule

@@ hw/rtl/ap_station_table_learner_unit.sv @@
// Access point / station learning table.
// s_ channel: one beat per received frame header (or a clear command),
// s_ready is high only while the sequencer is idle.
// m_ channel: one result beat per input beat, held in an output register.
// cfg channel: min_beacon_length write, always ready, write only when idle.
// A clear beat goes from idle straight to the output state. A frame walks
// an access point read and compare per access point compared, a station
// read and compare per station compared, a new-station step when a station
// is appended or the list is full, then a finish and an output step. One
// shared 48-bit comparator checks one table entry at a time, a memory read
// then a compare. The next beat is taken only once the sequencer is idle;
// it may be taken while the previous result still waits on m_ready.
// Reset: AP count cleared, min_beacon_length back to 70, no result pending.
// The tables need no clearing pass: only entries below the counts are read.
// Receiver stall: a finished result waits in the sequencer until the
// output register is free; input stays blocked meanwhile.
// ---------------------------------------------------------------------------
// ap_station_table_learner_unit
// Learns access points and their stations from frame header beats.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ap_station_table_learner_unit_defines.svh"

module ap_station_table_learner_unit (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  apstl_pkg::in_t          s_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output apstl_pkg::out_t         m_data,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [apstl_pkg::LEN_W-1:0] cfg_data
);
    import apstl_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_AP_RD  = 3'd1;
    localparam logic [2:0] ST_AP_CMP = 3'd2;
    localparam logic [2:0] ST_SL_RD  = 3'd3;
    localparam logic [2:0] ST_SL_CMP = 3'd4;
    localparam logic [2:0] ST_SL_NEW = 3'd5;
    localparam logic [2:0] ST_FIN    = 3'd6;
    localparam logic [2:0] ST_OUT    = 3'd7;

    logic [2:0]          state_reg, state_next;
    logic [LEN_W-1:0]    min_len_reg, min_len_next;
    logic [AP_CNT_W-1:0] ap_count_reg, ap_count_next;
    logic                m_valid_reg, m_valid_next;

    in_t                 item_reg, item_next;
    logic [ADDR_W-1:0]   sta_reg, sta_next;
    logic [AP_CNT_W-1:0] ap_scan_reg, ap_scan_next;
    logic [ST_CNT_W-1:0] st_scan_reg, st_scan_next;
    logic                match_reg, match_next;
    logic [AP_IDX_W-1:0] ap_idx_reg, ap_idx_next;
    logic [ST_CNT_W-1:0] st_cnt_reg, st_cnt_next;
    out_t                res_reg, res_next;
    out_t                m_data_reg, m_data_next;

    logic [ST_CNT_W-1:0] st_count_mem [AP_ENTRIES];
    logic [ST_CNT_W-1:0] st_cnt_rd_reg;
    logic                cnt_we;
    logic [AP_IDX_W-1:0] cnt_addr;
    logic [ST_CNT_W-1:0] cnt_wdata;

    store_ctl_t          ctl;
    logic [ADDR_W-1:0]   ap_bssid_q;
    logic [ADDR_W-1:0]   st_mac_q;

    logic [ADDR_W-1:0]   cmp_a;
    logic [ADDR_W-1:0]   cmp_b;
    logic                cmp_eq;
    logic [AP_CNT_W-1:0] ap_scan_inc;
    logic [ST_CNT_W-1:0] st_scan_inc;
    logic [ST_CNT_W-1:0] st_cnt_inc;
    logic [AP_IDX_W-1:0] ap_scan_idx;
    logic [AP_IDX_W-1:0] ap_new_idx;
    logic                beacon_ok;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // shared comparator: access point bssid or station address
    assign cmp_a  = (state_reg == ST_SL_CMP) ? st_mac_q : ap_bssid_q;
    assign cmp_b  = (state_reg == ST_SL_CMP) ? sta_reg : item_reg.bssid_address;
    assign cmp_eq = (cmp_a == cmp_b);

    assign ap_scan_inc = AP_CNT_W'(ap_scan_reg + 1'b1);
    assign st_scan_inc = ST_CNT_W'(st_scan_reg + 1'b1);
    assign st_cnt_inc  = ST_CNT_W'(st_cnt_reg + 1'b1);
    assign ap_scan_idx = ap_scan_reg[AP_IDX_W-1:0];
    assign ap_new_idx  = ap_count_reg[AP_IDX_W-1:0];
    assign beacon_ok   = (item_reg.kind == KIND_BEACON) &&
                         (item_reg.frame_length >= min_len_reg);

    always_comb begin
        state_next    = state_reg;
        min_len_next  = min_len_reg;
        ap_count_next = ap_count_reg;
        m_valid_next  = m_valid_reg;
        item_next     = item_reg;
        sta_next      = sta_reg;
        ap_scan_next  = ap_scan_reg;
        st_scan_next  = st_scan_reg;
        match_next    = match_reg;
        ap_idx_next   = ap_idx_reg;
        st_cnt_next   = st_cnt_reg;
        res_next      = res_reg;
        m_data_next   = m_data_reg;
        cnt_we        = 1'b0;
        cnt_addr      = ap_idx_reg;
        cnt_wdata     = st_cnt_inc;

        ctl             = '0;
        ctl.ap_addr     = ap_scan_idx;
        ctl.st_addr     = {ap_idx_reg, st_scan_reg[ST_IDX_W-1:0]};
        ctl.bssid       = item_reg.bssid_address;
        ctl.mac         = sta_reg;
        ctl.strength    = $unsigned(item_reg.signal_strength);
        ctl.channel     = item_reg.radio_channel;

        if (cfg_valid && cfg_ready) begin
            min_len_next = cfg_data;
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    item_next    = s_data;
                    sta_next     = (s_data.receiver_address == s_data.bssid_address) ?
                                   s_data.transmitter_address : s_data.receiver_address;
                    ap_scan_next = '0;
                    match_next   = 1'b0;
                    ap_idx_next  = '0;
                    res_next     = '0;
                    if (s_data.kind == KIND_CLEAR) begin
                        ap_count_next = '0;
                        state_next    = ST_OUT;
                    end else if (ap_count_reg == '0) begin
                        state_next = ST_FIN;
                    end else begin
                        state_next = ST_AP_RD;
                    end
                end
            end
            ST_AP_RD: begin
                state_next = ST_AP_CMP;
            end
            ST_AP_CMP: begin
                if (cmp_eq) begin
                    match_next           = 1'b1;
                    ap_idx_next          = ap_scan_idx;
                    st_cnt_next          = st_cnt_rd_reg;
                    st_scan_next         = '0;
                    res_next.ap_slot     = AP_SLOT_W'(ap_scan_idx);
                    if (st_cnt_rd_reg == '0) begin
                        state_next = ST_SL_NEW;
                    end else begin
                        state_next = ST_SL_RD;
                    end
                end else begin
                    ap_scan_next = ap_scan_inc;
                    if (ap_scan_inc == ap_count_reg) begin
                        state_next = ST_FIN;
                    end else begin
                        state_next = ST_AP_RD;
                    end
                end
            end
            ST_SL_RD: begin
                state_next = ST_SL_CMP;
            end
            ST_SL_CMP: begin
                if (cmp_eq) begin
                    ctl.st_str_we           = 1'b1;
                    res_next.station_slot   = ST_SLOT_W'(st_scan_reg);
                    res_next.station_action = ACT_UPDATED;
                    res_next.station_total  = ST_TOTAL_W'(st_cnt_reg);
                    state_next              = ST_FIN;
                end else begin
                    st_scan_next = st_scan_inc;
                    if (st_scan_inc == st_cnt_reg) begin
                        state_next = ST_SL_NEW;
                    end else begin
                        state_next = ST_SL_RD;
                    end
                end
            end
            ST_SL_NEW: begin
                ctl.st_addr = {ap_idx_reg, st_cnt_reg[ST_IDX_W-1:0]};
                if (st_cnt_reg < ST_CNT_W'(ST_ENTRIES)) begin
                    ctl.st_mac_we           = 1'b1;
                    ctl.st_str_we           = 1'b1;
                    cnt_we                  = 1'b1;
                    res_next.station_slot   = ST_SLOT_W'(st_cnt_reg);
                    res_next.station_action = ACT_CREATED;
                    res_next.station_total  = ST_TOTAL_W'(st_cnt_inc);
                end else begin
                    res_next.station_slot   = '0;
                    res_next.station_action = ACT_FULL;
                    res_next.station_total  = ST_TOTAL_W'(st_cnt_reg);
                end
                state_next = ST_FIN;
            end
            ST_FIN: begin
                ctl.ap_addr = match_reg ? ap_idx_reg : ap_new_idx;
                if (beacon_ok) begin
                    if (match_reg) begin
                        ctl.ap_str_we      = 1'b1;
                        res_next.ap_action = ACT_UPDATED;
                    end else if (item_reg.ssid_length != '0) begin
                        if (ap_count_reg < AP_CNT_W'(AP_ENTRIES)) begin
                            ctl.ap_bssid_we        = 1'b1;
                            ctl.ap_str_we          = 1'b1;
                            ctl.ap_chan_we         = 1'b1;
                            cnt_we                 = 1'b1;
                            cnt_addr               = ap_new_idx;
                            cnt_wdata              = '0;
                            ap_count_next          = AP_CNT_W'(ap_count_reg + 1'b1);
                            res_next.ap_slot       = AP_SLOT_W'(ap_new_idx);
                            res_next.ap_action     = ACT_CREATED;
                            res_next.station_total = '0;
                        end else begin
                            res_next.ap_slot   = '0;
                            res_next.ap_action = ACT_FULL;
                        end
                    end
                end
                res_next.ap_total = AP_TOTAL_W'(ap_count_next);
                state_next        = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            min_len_reg  <= MIN_BEACON_RESET;
            ap_count_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            min_len_reg  <= min_len_next;
            ap_count_reg <= ap_count_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg    <= item_next;
        sta_reg     <= sta_next;
        ap_scan_reg <= ap_scan_next;
        st_scan_reg <= st_scan_next;
        match_reg   <= match_next;
        ap_idx_reg  <= ap_idx_next;
        st_cnt_reg  <= st_cnt_next;
        res_reg     <= res_next;
        m_data_reg  <= m_data_next;
        if (cnt_we) begin
            st_count_mem[cnt_addr] <= cnt_wdata;
        end
        st_cnt_rd_reg <= st_count_mem[ap_scan_idx];
    end

    apstl_store u_store (
        .aclk       (aclk),
        .ctl        (ctl),
        .ap_bssid_q (ap_bssid_q),
        .st_mac_q   (st_mac_q)
    );

    `APSTL_ASSERT(a_ap_count_range, ap_count_reg <= AP_CNT_W'(AP_ENTRIES), "ap count overflow")
    `APSTL_ASSERT(a_ap_count_step,
        (ap_count_reg != $past(ap_count_reg)) |-> ((ap_count_reg == '0) ||
        (ap_count_reg == AP_CNT_W'($past(ap_count_reg) + 1'b1))),
        "ap count jumped")
    `APSTL_ASSERT(a_busy_after_accept, (s_valid && s_ready) |=> !s_ready,
        "second beat taken while busy")
    `APSTL_ASSERT(a_result_from_out, $rose(m_valid) |-> $past(state_reg == ST_OUT),
        "result without sequencer")
    `APSTL_ASSERT_ALWAYS(a_no_result_in_reset, !aresetn |=> !m_valid,
        "result pending after reset")

endmodule
